### rtl/pvtsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pvtsc_pkg;

  // Default number of intervals of the cubic check
  localparam int unsigned SAMPLES_DEF = 50;

  // Port widths
  localparam int unsigned IN_W  = 128;
  localparam int unsigned OUT_W = 40;
  localparam int unsigned CFG_W = 16;

  // Register indexes
  localparam logic REG_TRAJ_MODE = 1'b0;
  localparam logic REG_SPEED_EPS = 1'b1;

  // Trajectory mode codes (every other code runs the fraction adjustment)
  localparam logic [1:0] MODE_CUBIC  = 2'd0;
  localparam logic [1:0] MODE_TRAP   = 2'd1;
  localparam logic [1:0] MODE_SCURVE = 2'd2;

  // One in Q1.15
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // Divider operand widths
  localparam int unsigned DIV_NW = 64;
  localparam int unsigned DIV_DW = 48;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic ld_in;
    logic prep;
    logic decide;
    logic cub_start;
    logic cub_issue;
    logic trap_ta;
    logic trap_mul;
    logic trap_sum;
    logic div_num;
    logic eval_u;
    logic div_ratio;
    logic apply_eps;
    logic apply_ratio;
    logic commit;
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic skip;
    logic cubic;
    logic dp_zero;
    logic pipe_busy;
    logic div_busy;
    logic opp;
  } stat_t;

endpackage

`default_nettype wire

### rtl/pvtsc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module pvtsc_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [pvtsc_pkg::DIV_NW-1:0] dividend_i,
  input  wire logic signed [pvtsc_pkg::DIV_DW-1:0] divisor_i,
  output logic                                     busy_o,
  output logic signed [pvtsc_pkg::DIV_NW-1:0]      quot_o
);
  import pvtsc_pkg::*;

  localparam int unsigned QW    = DIV_NW - 1;
  localparam int unsigned NSTEP = QW;
  localparam int unsigned CW    = $clog2(NSTEP);
  localparam logic [QW-1:0] SAT_MAG = QW'(1) << 62;

  logic              busy_q;
  logic [CW-1:0]     cnt_q;
  logic              neg_q;
  logic [QW-1:0]     dq_q;
  logic [DIV_DW-1:0] rem_q;
  logic [DIV_DW-1:0] dmag_q;

  logic [DIV_NW-1:0] nabs;
  logic [DIV_DW-1:0] dabs;
  logic [DIV_DW:0]   rs;
  logic              ge;

  // Operand magnitudes and one restoring step
  always_comb begin
    nabs = dividend_i[DIV_NW-1] ? DIV_NW'(-dividend_i) : DIV_NW'(dividend_i);
    dabs = divisor_i[DIV_DW-1] ? DIV_DW'(-divisor_i) : DIV_DW'(divisor_i);
    rs   = {rem_q, dq_q[QW-1]};
    ge   = rs >= {1'b0, dmag_q};
  end

  // Control: busy and step count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (divisor_i != '0);
      cnt_q  <= CW'(NSTEP - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Datapath: shift one quotient bit a cycle; saturate on a zero divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dmag_q <= dabs;
      if (divisor_i == '0) begin
        dq_q  <= (dividend_i == '0) ? '0 : SAT_MAG;
        neg_q <= dividend_i[DIV_NW-1];
      end else begin
        dq_q  <= nabs[QW-1:0];
        neg_q <= dividend_i[DIV_NW-1] ^ divisor_i[DIV_DW-1];
      end
    end else if (busy_q) begin
      rem_q <= ge ? DIV_DW'(rs - {1'b0, dmag_q}) : rs[DIV_DW-1:0];
      dq_q  <= {dq_q[QW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});

endmodule

`default_nettype wire

### rtl/pvtsc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module pvtsc_dpath #(
  parameter int unsigned SAMPLES = pvtsc_pkg::SAMPLES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pvtsc_pkg::cmd_t               cmd_i,
  output pvtsc_pkg::stat_t                   stat_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_addr_i,
  input  wire logic [pvtsc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  wire logic [pvtsc_pkg::IN_W-1:0]    in_data_i,
  input  wire logic                          in_last_i,
  output logic [pvtsc_pkg::OUT_W-1:0]        out_data_o,
  output logic                               out_last_o
);
  import pvtsc_pkg::*;

  localparam int unsigned SQ = 65536 / SAMPLES;
  localparam int unsigned SR = 65536 % SAMPLES;
  localparam int unsigned LW = $clog2(SAMPLES);
  localparam int unsigned NSTG = 8;
  localparam logic signed [71:0] SAT_HI = 72'sd4611686018427387904;
  localparam logic signed [71:0] SAT_LO = -72'sd4611686018427387904;

  // Clamp to plus or minus 2^62
  function automatic logic signed [63:0] sat62(input logic signed [71:0] x);
    logic signed [71:0] y;
    y = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
    return y[63:0];
  endfunction

  // Speed below epsilon counts as zero
  function automatic logic signed [31:0] zap(input logic signed [31:0] v,
                                             input logic [15:0] e);
    logic [32:0] m;
    m = v[31] ? 33'(-$signed({v[31], v})) : {1'b0, v};
    return (m < {17'd0, e}) ? 32'sd0 : v;
  endfunction

  // Limit a fraction to one
  function automatic logic [15:0] sat_frac(input logic [15:0] f);
    return (f > ONE_Q15) ? ONE_Q15 : f;
  endfunction

  // Configuration
  logic [1:0]  mode_q;
  logic [15:0] eps_q;

  // Current point
  logic signed [31:0] pos_q, vel_q;
  logic [31:0]        tim_q;
  logic [15:0]        na_q, nd_q;
  logic               last_q;

  // Trajectory state
  logic signed [31:0] prev_pos_q, prev_vel_q;
  logic [31:0]        prev_time_q;
  logic [15:0]        prev_acc_q, prev_dec_q;
  logic               have_prev_q, bad_seen_q;

  // Segment quantities
  logic signed [32:0] dp_q, t_q;
  logic signed [31:0] v0_q, v1_q;
  logic               seg_bad_q;

  // Output register
  logic        o_bad_q, o_any_q, o_last_q;
  logic [15:0] o_na_q, o_nd_q;

  // Segment sign checks
  logic dp_pos, dp_neg, v0_pos, v0_neg, v1_pos, v1_neg, both_zero, conflict;
  logic signed [32:0] vsum;
  logic signed [33:0] v2sum;

  always_comb begin
    dp_neg    = dp_q[32];
    dp_pos    = !dp_q[32] && (dp_q != '0);
    v0_neg    = v0_q[31];
    v0_pos    = !v0_q[31] && (v0_q != '0);
    v1_neg    = v1_q[31];
    v1_pos    = !v1_q[31] && (v1_q != '0);
    both_zero = (v0_q == '0) && (v1_q == '0);
    conflict  = (dp_pos && v1_neg) || (dp_neg && v1_pos) ||
                (v0_neg && v1_pos) || (v0_pos && v1_neg);
    vsum      = $signed({v0_q[31], v0_q}) + $signed({v1_q[31], v1_q});
    v2sum     = $signed({v0_q[31], v0_q, 1'b0}) + $signed({{2{v1_q[31]}}, v1_q});
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CUBIC;
      eps_q  <= 16'd7;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TRAJ_MODE: mode_q <= cfg_wdata_i[1:0];
        REG_SPEED_EPS: eps_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Cubic sampling pipeline
  // ---------------------------------------------------------------------
  logic [15:0]   s_q;
  logic [LW-1:0] rem_q;
  logic [LW:0]   rem_sum;
  logic [NSTG-1:0] cv_q;

  logic [15:0]        s0_q, s1_q, s2_q, s3_q;
  logic [31:0]        sq1_q, sq2_q;
  logic [47:0]        cu2_q;
  logic [16:0]        h3_q;
  logic [15:0]        w2_3_q, w3_3_q;
  logic signed [49:0] pa4_q;
  logic signed [50:0] pb4_q;
  logic signed [48:0] pc4_q;
  logic signed [50:0] pd4_q;
  logic signed [35:0] g5_q;
  logic signed [34:0] o5_q, o6_q, o7_q;
  logic signed [51:0] ml6_q;
  logic signed [50:0] mh6_q;
  logic signed [63:0] pr7_q;

  logic [50:0]        hn;
  logic signed [51:0] g;
  logic signed [71:0] full;
  logic signed [48:0] off;
  logic               smp_bad;

  always_comb begin
    rem_sum = {1'b0, rem_q} + (LW+1)'(SR);
    hn      = 51'({sq2_q, 16'd0}) + 51'({sq2_q, 17'd0}) - 51'({cu2_q, 1'b0});
    g       = pa4_q - pb4_q + pc4_q;
    full    = $signed({{3{mh6_q[50]}}, mh6_q, 18'd0}) + $signed({{20{ml6_q[51]}}, ml6_q});
    off     = $signed(pr7_q[63:16]) + o7_q;
    smp_bad = (dp_pos && (off[48] || (off > dp_q))) ||
              (dp_neg && ((off < dp_q) || (!off[48] && (off != '0))));
  end

  // Sample generator: s = floor(j * 65536 / SAMPLES) by running remainder
  always_ff @(posedge clk_i) begin
    if (cmd_i.cub_start) begin
      s_q   <= 16'(SQ);
      rem_q <= LW'(SR);
    end else if (cmd_i.cub_issue) begin
      if (rem_sum >= (LW+1)'(SAMPLES)) begin
        s_q   <= s_q + 16'(SQ + 1);
        rem_q <= LW'(rem_sum - (LW+1)'(SAMPLES));
      end else begin
        s_q   <= s_q + 16'(SQ);
        rem_q <= rem_sum[LW-1:0];
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else begin
      cv_q <= {cv_q[NSTG-2:0], cmd_i.cub_issue};
    end
  end

  // Stage registers: powers, Hermite weights, products, offset
  always_ff @(posedge clk_i) begin
    s0_q   <= s_q;
    s1_q   <= s0_q;
    sq1_q  <= s0_q * s0_q;
    s2_q   <= s1_q;
    sq2_q  <= sq1_q;
    cu2_q  <= sq1_q * s1_q;
    s3_q   <= s2_q;
    h3_q   <= hn[48:32];
    w2_3_q <= sq2_q[31:16];
    w3_3_q <= cu2_q[47:32];
    pa4_q  <= vsum * $signed({1'b0, w3_3_q});
    pb4_q  <= v2sum * $signed({1'b0, w2_3_q});
    pc4_q  <= v0_q * $signed({1'b0, s3_q});
    pd4_q  <= dp_q * $signed({1'b0, h3_q});
    g5_q   <= g[51:16];
    o5_q   <= pd4_q[50:16];
    ml6_q  <= t_q * $signed({1'b0, g5_q[17:0]});
    mh6_q  <= t_q * $signed(g5_q[35:18]);
    o6_q   <= o5_q;
    pr7_q  <= sat62(full);
    o7_q   <= o6_q;
  end

  // ---------------------------------------------------------------------
  // Trapezoid / S-curve fraction adjustment
  // ---------------------------------------------------------------------
  logic signed [33:0] ta_q, td_q;
  logic signed [65:0] m0_q, m1_q, ms_q;
  logic signed [49:0] num_q;
  logic signed [35:0] den_q;
  logic signed [47:0] d2_q;
  logic opp_q, e0_lt_q, e0_gt_q, e1_lt_q, e1_gt_q;

  logic signed [49:0] pta, ptd;
  logic signed [63:0] c0, c1, cs, nsat;
  logic signed [65:0] d0, d1;
  logic [65:0]        a0, a1;

  logic                      div_start, div_busy;
  logic signed [DIV_NW-1:0]  div_n, quot;
  logic signed [DIV_DW-1:0]  div_d;

  always_comb begin
    pta  = $signed({1'b0, prev_acc_q}) * t_q;
    ptd  = $signed({1'b0, prev_dec_q}) * t_q;
    c0   = sat62($signed({{6{m0_q[65]}}, m0_q}));
    c1   = sat62($signed({{6{m1_q[65]}}, m1_q}));
    cs   = sat62($signed({{6{ms_q[65]}}, ms_q}));
    nsat = sat62($signed({{6{num_q[49]}}, num_q, 16'd0}));
    d0   = $signed({{34{v0_q[31]}}, v0_q}) - $signed({{2{quot[63]}}, quot});
    d1   = $signed({{34{v1_q[31]}}, v1_q}) - $signed({{2{quot[63]}}, quot});
    a0   = d0[65] ? 66'(-d0) : 66'(d0);
    a1   = d1[65] ? 66'(-d1) : 66'(d1);
    div_start = cmd_i.div_num || cmd_i.div_ratio;
    if (cmd_i.div_ratio) begin
      div_n = $signed({{15{dp_q[32]}}, dp_q, 16'd0});
      div_d = d2_q;
    end else begin
      div_n = nsat;
      div_d = $signed({{12{den_q[35]}}, den_q});
    end
  end

  pvtsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // Trapezoid registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.trap_ta) begin
      ta_q <= pta[49:16];
      td_q <= ptd[49:16];
    end
    if (cmd_i.trap_mul) begin
      m0_q <= v0_q * ta_q;
      m1_q <= v1_q * td_q;
      ms_q <= vsum * t_q;
    end
    if (cmd_i.trap_sum) begin
      num_q <= dp_q - $signed(c0[63:16]) - $signed(c1[63:16]);
      den_q <= t_q - ta_q - td_q;
      d2_q  <= cs[63:16];
    end
    if (cmd_i.eval_u) begin
      opp_q   <= (dp_pos && quot[63]) || (dp_neg && !quot[63] && (quot != '0));
      e0_lt_q <= a0 < {50'd0, eps_q};
      e0_gt_q <= a0 > {50'd0, eps_q};
      e1_lt_q <= a1 < {50'd0, eps_q};
      e1_gt_q <= a1 > {50'd0, eps_q};
    end
  end

  // ---------------------------------------------------------------------
  // Point load, segment set-up, fractions and verdict
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      pos_q  <= in_data_i[31:0];
      vel_q  <= in_data_i[63:32];
      tim_q  <= in_data_i[95:64];
      na_q   <= sat_frac(in_data_i[111:96]);
      nd_q   <= sat_frac(in_data_i[127:112]);
      last_q <= in_last_i;
    end
    if (cmd_i.prep) begin
      dp_q <= $signed({pos_q[31], pos_q}) - $signed({prev_pos_q[31], prev_pos_q});
      t_q  <= $signed({1'b0, tim_q}) - $signed({1'b0, prev_time_q});
      v0_q <= zap(prev_vel_q, eps_q);
      v1_q <= zap(vel_q, eps_q);
    end
    if (cmd_i.decide) begin
      seg_bad_q <= have_prev_q && !both_zero && conflict;
    end else if (cv_q[NSTG-1] && smp_bad) begin
      seg_bad_q <= 1'b1;
    end
    if (cmd_i.apply_eps) begin
      if (e0_lt_q && e1_lt_q) begin
        na_q <= '0;
        nd_q <= '0;
      end else if ((e0_lt_q && e1_gt_q) || (e0_gt_q && e1_lt_q)) begin
        na_q <= na_q >> 1;
        nd_q <= nd_q >> 1;
      end
    end
    if (cmd_i.apply_ratio) begin
      if (quot[63]) begin
        na_q <= '0;
        nd_q <= '0;
      end else if (quot > $signed({48'd0, ONE_Q15})) begin
        na_q <= ONE_Q15;
        nd_q <= ONE_Q15;
      end else begin
        na_q <= quot[15:0];
        nd_q <= quot[15:0];
      end
    end
    if (cmd_i.commit) begin
      o_bad_q  <= seg_bad_q;
      o_any_q  <= bad_seen_q || seg_bad_q;
      o_na_q   <= na_q;
      o_nd_q   <= nd_q;
      o_last_q <= last_q;
    end
  end

  // Trajectory state: advance on commit, clear after the last point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pos_q  <= '0;
      prev_vel_q  <= '0;
      prev_time_q <= '0;
      prev_acc_q  <= '0;
      prev_dec_q  <= '0;
      have_prev_q <= 1'b0;
      bad_seen_q  <= 1'b0;
    end else if (cmd_i.commit) begin
      if (last_q) begin
        prev_pos_q  <= '0;
        prev_vel_q  <= '0;
        prev_time_q <= '0;
        prev_acc_q  <= '0;
        prev_dec_q  <= '0;
        have_prev_q <= 1'b0;
        bad_seen_q  <= 1'b0;
      end else begin
        prev_pos_q  <= pos_q;
        prev_vel_q  <= vel_q;
        prev_time_q <= tim_q;
        prev_acc_q  <= na_q;
        prev_dec_q  <= nd_q;
        have_prev_q <= 1'b1;
        bad_seen_q  <= bad_seen_q || seg_bad_q;
      end
    end
  end

  // Status to the sequencer
  always_comb begin
    stat_o.skip      = !have_prev_q || both_zero || conflict;
    stat_o.cubic     = (mode_q == MODE_CUBIC);
    stat_o.dp_zero   = (dp_q == '0);
    stat_o.pipe_busy = |cv_q;
    stat_o.div_busy  = div_busy;
    stat_o.opp       = opp_q;
  end

  assign out_data_o = {6'd0, o_any_q, o_nd_q, o_na_q, o_bad_q};
  assign out_last_o = o_last_q;

endmodule

`default_nettype wire

### rtl/pvtsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pvtsc_ctrl #(
  parameter int unsigned SAMPLES = pvtsc_pkg::SAMPLES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire pvtsc_pkg::stat_t stat_i,
  output pvtsc_pkg::cmd_t       cmd_o
);
  import pvtsc_pkg::*;

  localparam int unsigned JW = $clog2(SAMPLES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DECIDE, ST_CUB, ST_DRAIN, ST_TA, ST_MUL, ST_SUM,
    ST_DIV1, ST_DIV1W, ST_EVAL, ST_TDEC, ST_DIV2W, ST_FIN
  } state_e;

  state_e      state_q, state_d;
  logic [JW-1:0] j_q, j_d;
  logic        out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_in = 1'b1;
          state_d     = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        if (stat_i.skip || (stat_i.cubic && stat_i.dp_zero)) begin
          state_d = ST_FIN;
        end else if (stat_i.cubic) begin
          cmd_o.cub_start = 1'b1;
          j_d             = '0;
          state_d         = ST_CUB;
        end else begin
          state_d = ST_TA;
        end
      end
      ST_CUB: begin
        cmd_o.cub_issue = 1'b1;
        j_d             = j_q + JW'(1);
        if (j_q == JW'(SAMPLES - 2)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_TA: begin
        cmd_o.trap_ta = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.trap_mul = 1'b1;
        state_d        = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.trap_sum = 1'b1;
        state_d        = ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.div_num = 1'b1;
        state_d       = ST_DIV1W;
      end
      ST_DIV1W: begin
        if (!stat_i.div_busy) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd_o.eval_u = 1'b1;
        state_d      = ST_TDEC;
      end
      ST_TDEC: begin
        if (stat_i.opp) begin
          cmd_o.div_ratio = 1'b1;
          state_d         = ST_DIV2W;
        end else begin
          cmd_o.apply_eps = 1'b1;
          state_d         = ST_FIN;
        end
      end
      ST_DIV2W: begin
        if (!stat_i.div_busy) begin
          cmd_o.apply_ratio = 1'b1;
          state_d           = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Hold state, sample count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_cub_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CUB) |-> (j_q <= JW'(SAMPLES - 2)))
    else $error("sample count ran past the last interior sample");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && (state_q != ST_IDLE ||
    !$past(cmd_o.commit))))
    else $error("pending result dropped");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV1W && !stat_i.div_busy) |=> (state_q == ST_EVAL))
    else $error("quotient not evaluated after division");
`endif

endmodule

`default_nettype wire

### rtl/pvt_segment_checker_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                 Payload
// s_axis    tvalid/tready/tdata     position, velocity, time_stamp, acc/dec fraction
//           tlast                   last_point
// m_axis    tvalid/tready/tdata     segment_bad, next acc/dec fraction, any_bad
//           tlast                   final_result
// cfg       cfg_we_i/addr/wdata     traj_mode (0), speed_epsilon (1)
//
// One request at a time. First point, zero-speed or conflicting segment: the check is skipped.
// Cubic mode: one sample a cycle through an 8-stage pipeline.
// Trapezoid/S mode: one division, or two when the fraction ratio is needed;
// each division runs through the 63-step serial divider.
// Reset clears trajectory state, configuration and control state at once; no clearing pass.
// A result waiting on m_axis does not stop the next request being taken.
module pvt_segment_checker_top #(
  parameter int unsigned SAMPLES = pvtsc_pkg::SAMPLES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_addr_i,
  input  wire logic [pvtsc_pkg::CFG_W-1:0] cfg_wdata_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] position, [63:32] velocity, [95:64] time_stamp,
  // [111:96] acc_fraction, [127:112] dec_fraction
  input  wire logic [pvtsc_pkg::IN_W-1:0]  s_axis_tdata,
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [0] segment_bad, [16:1] next_acc_fraction, [32:17] next_dec_fraction,
  // [33] any_bad, [39:34] zero
  output logic [pvtsc_pkg::OUT_W-1:0]      m_axis_tdata,
  output logic                             m_axis_tlast
);
  import pvtsc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pvtsc_ctrl #(
    .SAMPLES (SAMPLES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pvtsc_dpath #(
    .SAMPLES (SAMPLES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire
